[rtl/core/afrf_pkg.sv]
package afrf_pkg;

    localparam int DEF_MAX_FRAMES = 4096;
    localparam int DEF_FRAME_BITS = 32;
    localparam int CAP_RESET      = 4096;

    localparam int OP_W   = 3;
    localparam int OFF_W  = 12;
    localparam int LEN_W  = 13;
    localparam int TAG_W  = 16;
    localparam int CAP_W  = 13;
    localparam int FILL_W = 13;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_PEEK   = 3'd1,
        OP_REMOVE = 3'd2,
        OP_MARK   = 3'd3,
        OP_CLEAR  = 3'd4
    } afrf_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_EXEC,
        ST_DONE
    } afrf_state_t;

endpackage

[rtl/core/audio_frame_ring_fifo_with_marker.sv]
// An accepted beat passes through the states ST_MOD, ST_EXEC and ST_DONE; in ST_MOD
// the offset, when not below the capacity, is reduced one bit a cycle.
// No new beat is accepted until the previous result has been loaded for output.
// Reset clears the head pointer, the fill count and the marker and sets the capacity to
// 4096 slots (or the maximum if smaller); the frame memory itself is not cleared.
module audio_frame_ring_fifo_with_marker
    import afrf_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int FRAME_BITS = DEF_FRAME_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // frame_in, offset, length, marker_tag
    input  logic [((FRAME_BITS + OFF_W + LEN_W + TAG_W + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // frame_out, marker_hit, accepted, fill_level
    output logic [((FRAME_BITS + TAG_W + 1 + FILL_W + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAP_W-1:0]     cfg_data
);

    localparam int IDX_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W    = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int CMP_W    = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int OUT_W    = ((FRAME_BITS + TAG_W + 1 + FILL_W + 7) / 8) * 8;
    localparam int CAP_INIT = (CAP_RESET > MAX_FRAMES) ? MAX_FRAMES : CAP_RESET;

    function automatic logic [IDX_W-1:0] wrap_add(
        input logic [CNT_W-1:0] a,
        input logic [CNT_W-1:0] b,
        input logic [CNT_W-1:0] cap
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(cap)) begin
            s = s - SUM_W'(cap);
        end
        return s[IDX_W-1:0];
    endfunction

    afrf_state_t state_reg, state_next;

    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [TAG_W-1:0] mid_reg, mid_next;
    logic [IDX_W-1:0] midx_reg, midx_next;
    logic             m_valid_reg, m_valid_next;

    logic [OP_W-1:0]       op_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [OFF_W-1:0]      off_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [IDX_W-1:0]      tail_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [IDX_W-1:0]      mpos_reg;
    logic                  hit_reg;
    logic                  acc_reg;
    logic                  peek_reg;

    logic [FRAME_BITS-1:0] m_frame_reg;
    logic [TAG_W-1:0]      m_hit_reg;
    logic                  m_acc_reg;
    logic [FILL_W-1:0]     m_fill_reg;

    logic [FRAME_BITS-1:0] s_frame;
    logic [OFF_W-1:0]      s_off;
    logic [LEN_W-1:0]      s_len;
    logic [TAG_W-1:0]      s_tag;

    logic             s_acc;
    logic             cfg_acc;
    logic             load;
    logic             mod_done;
    logic [CNT_W-1:0] mod_rem;
    logic [CNT_W-1:0] cap_cfg;
    logic             has_room;
    logic             peek_ok;
    logic [CMP_W-1:0] off_w;
    logic [CMP_W-1:0] cnt_w;
    logic [CMP_W-1:0] len_w;
    logic [CMP_W-1:0] avail;
    logic [CNT_W-1:0] peek_n;
    logic [CNT_W-1:0] rm_n;
    logic [CNT_W-1:0] n_sel;
    logic [SUM_W-1:0] mark_dist;
    logic             in_range;
    logic             ram_we;
    logic             ram_re;
    logic [FRAME_BITS-1:0] ram_rdata;

    assign s_frame = s_tdata[FRAME_BITS-1:0];
    assign s_off   = s_tdata[FRAME_BITS +: OFF_W];
    assign s_len   = s_tdata[FRAME_BITS + OFF_W +: LEN_W];
    assign s_tag   = s_tdata[FRAME_BITS + OFF_W + LEN_W +: TAG_W];

    assign s_acc   = s_tvalid && s_tready;
    assign cfg_acc = cfg_valid && cfg_ready;

    afrf_mod #(
        .CNT_W (CNT_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_acc),
        .dividend  (s_off),
        .divisor   (cap_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    afrf_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (frame_reg),
        .re    (ram_re),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (cfg_data == '0) begin
            cap_cfg = CNT_W'(1);
        end else if (int'(cfg_data) > MAX_FRAMES) begin
            cap_cfg = CNT_W'(MAX_FRAMES);
        end else begin
            cap_cfg = CNT_W'(cfg_data);
        end

        has_room = count_reg < cap_reg;
        off_w    = CMP_W'(off_reg);
        cnt_w    = CMP_W'(count_reg);
        len_w    = CMP_W'(len_reg);
        peek_ok  = (len_reg != '0) && (off_w < cnt_w);
        avail    = cnt_w - off_w;
        peek_n   = CNT_W'((len_w < avail) ? len_w : avail);
        rm_n     = CNT_W'((len_w < cnt_w) ? len_w : cnt_w);
        if (op_reg == OP_PEEK) begin
            n_sel = peek_ok ? peek_n : '0;
        end else begin
            n_sel = rm_n;
        end
        mark_dist = SUM_W'(midx_reg) + SUM_W'(cap_reg) - SUM_W'(pos_reg);
        if (mark_dist >= SUM_W'(cap_reg)) begin
            mark_dist = mark_dist - SUM_W'(cap_reg);
        end
        in_range = (mid_reg != '0) && (n_sel != '0) && (mark_dist < SUM_W'(n_sel));
    end

    assign ram_we = (state_reg == ST_EXEC) && (op_reg == OP_PUSH) && has_room;
    assign ram_re = (state_reg == ST_EXEC) && (op_reg == OP_PEEK);
    assign load   = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        cap_next     = cap_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        mid_next     = mid_reg;
        midx_next    = midx_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = (state_reg == ST_IDLE) && !cfg_valid;
        cfg_ready    = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (cfg_acc) begin
                    cap_next   = cap_cfg;
                    head_next  = '0;
                    count_next = '0;
                    mid_next   = '0;
                end else if (s_acc) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (op_reg)
                    OP_PUSH: begin
                        if (has_room) begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_REMOVE: begin
                        if (in_range) begin
                            mid_next = '0;
                        end
                        head_next  = wrap_add(CNT_W'(head_reg), n_sel, cap_reg);
                        count_next = count_reg - n_sel;
                    end
                    OP_MARK: begin
                        mid_next  = tag_reg;
                        midx_next = mpos_reg;
                    end
                    OP_CLEAR: begin
                        head_next  = '0;
                        count_next = '0;
                        mid_next   = '0;
                    end
                    default: begin
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CNT_W'(CAP_INIT);
            head_reg    <= '0;
            count_reg   <= '0;
            mid_reg     <= '0;
            midx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            mid_reg     <= mid_next;
            midx_reg    <= midx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg    <= s_tuser;
            frame_reg <= s_frame;
            off_reg   <= s_off;
            len_reg   <= s_len;
            tag_reg   <= s_tag;
            tail_reg  <= wrap_add(CNT_W'(head_reg), count_reg, cap_reg);
        end
        if ((state_reg == ST_MOD) && mod_done) begin
            pos_reg  <= wrap_add(CNT_W'(head_reg), mod_rem, cap_reg);
            mpos_reg <= wrap_add(CNT_W'(tail_reg), mod_rem, cap_reg);
        end
        if (state_reg == ST_EXEC) begin
            hit_reg  <= (op_reg == OP_PEEK) && in_range;
            acc_reg  <= (op_reg == OP_PUSH) && has_room;
            peek_reg <= (op_reg == OP_PEEK) && peek_ok;
        end
        if (load) begin
            m_frame_reg <= peek_reg ? ram_rdata : '0;
            m_hit_reg   <= hit_reg ? mid_reg : '0;
            m_acc_reg   <= acc_reg;
            m_fill_reg  <= FILL_W'(count_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_fill_reg, m_acc_reg, m_hit_reg, m_frame_reg});

`ifndef SYNTHESIS
    a_fill_within_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_reg)
        else $error("fill count exceeds capacity");

    a_head_within_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(head_reg) < cap_reg)
        else $error("head index outside the ring");

    a_mod_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> state_reg == ST_MOD)
        else $error("offset reduction finished outside its wait state");

    a_accept_starts_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> state_reg == ST_MOD)
        else $error("accepted beat did not start processing");
`endif

endmodule

[rtl/core/afrf_ram.sv]
module afrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/afrf_mod.sv]
module afrf_mod
    import afrf_pkg::*;
#(
    parameter int CNT_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [OFF_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [CNT_W-1:0] remainder
);

    localparam int CW     = ((CNT_W > OFF_W) ? CNT_W : OFF_W) + 1;
    localparam int STEP_W = $clog2(OFF_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [OFF_W-1:0]  dvd_reg, dvd_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     cand;
    logic [CW-1:0]     cand_sub;
    logic              fast;

    always_comb begin
        cand     = {rem_reg[CW-2:0], dvd_reg[OFF_W-1]};
        cand_sub = (cand >= CW'(divisor)) ? (cand - CW'(divisor)) : cand;
        fast     = CW'(dividend) < CW'(divisor);

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start) begin
            if (fast) begin
                rem_next  = CW'(dividend);
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
                step_next = STEP_W'(OFF_W);
                dvd_next  = dividend;
                rem_next  = '0;
            end
        end else if (busy_reg) begin
            rem_next  = cand_sub;
            dvd_next  = {dvd_reg[OFF_W-2:0], 1'b0};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[CNT_W-1:0];

endmodule
